FILE: sv/power_key_auto_on_off_sequencer_defines.svh
// Assertion macros used by the power key sequencer checker.
`ifndef POWER_KEY_AUTO_ON_OFF_SEQUENCER_DEFINES_SVH
`define POWER_KEY_AUTO_ON_OFF_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PKAO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkao assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PKAO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkao assertion failed");

`endif

FILE: sv/pkao_pkg.sv
// Package with the types, constants and step functions of the power key sequencer.
`default_nettype none

package pkao_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] F_ENABLE   = 8'h01;
    localparam logic [7:0] F_WAKE_ACC = 8'h02;
    localparam logic [7:0] F_WAKE_M5V = 8'h04;
    localparam logic [7:0] F_WORK     = 8'h08;
    localparam logic [7:0] F_HOLD     = 8'h10;
    localparam logic [7:0] F_TIMEOUT  = 8'h20;
    localparam logic [7:0] F_SHUTDOWN = 8'h40;
    localparam logic [7:0] F_WAKE     = 8'h80;
    localparam logic [7:0] F_LOW_MASK = 8'h0F;
    localparam logic [7:0] F_NONE     = 8'h00;

    localparam logic [7:0]  SHORT_DELAY_RESET = 8'd10;
    localparam logic [7:0]  ONE_SECOND_RESET  = 8'd100;
    localparam logic [7:0]  TWO_SECOND_RESET  = 8'd200;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd3600;

    typedef enum logic [1:0] {
        REG_SHORT_DELAY = 2'd0,
        REG_ONE_SECOND  = 2'd1,
        REG_TWO_SECOND  = 2'd2,
        REG_TIMEOUT     = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SLEEP    = 3'd1,
        PH_WAKEKEY  = 3'd2,
        PH_ACC      = 3'd3,
        PH_ACC_HOLD = 3'd4,
        PH_M5V      = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0]  short_delay_ticks;
        logic [7:0]  one_second_ticks;
        logic [7:0]  two_second_ticks;
        logic [15:0] timeout_seconds;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  flags;
        logic [7:0]  tick;
        logic [15:0] secs;
        phase_t      phase;
        logic        key;
        logic        ten;
    } state_t;

    function automatic logic has(logic [7:0] flags, logic [7:0] mask);
        return (flags & mask) != F_NONE;
    endfunction

    // Timer handler: hold, timeout, shutdown press and wake press in that order.
    function automatic state_t timer_rules(state_t s, cfg_t c);
        state_t r;
        r = s;
        if (has(r.flags, F_HOLD)) begin
            if (r.tick == 8'd0) begin
                r.flags = r.flags & F_LOW_MASK;
                r.key   = 1'b0;
            end else begin
                r.tick = r.tick - 8'd1;
            end
        end
        if (has(r.flags, F_TIMEOUT)) begin
            if (r.tick == 8'd0) begin
                r.secs = r.secs - 16'd1;
                if (r.secs == 16'd0) begin
                    r.flags = (r.flags & ~F_TIMEOUT) | F_SHUTDOWN;
                end
                r.tick = c.one_second_ticks;
            end else begin
                r.tick = r.tick - 8'd1;
            end
        end
        if (has(r.flags, F_SHUTDOWN)) begin
            if (r.tick == 8'd0) begin
                r.key   = 1'b1;
                r.flags = (r.flags & F_ENABLE) | F_HOLD;
                r.tick  = c.two_second_ticks;
            end else begin
                r.tick = r.tick - 8'd1;
            end
        end
        if (has(r.flags, F_WAKE)) begin
            if (r.tick == 8'd0) begin
                r.key   = 1'b1;
                r.flags = (r.flags & F_LOW_MASK) | F_HOLD;
                r.tick  = c.two_second_ticks;
            end else begin
                r.tick = r.tick - 8'd1;
            end
        end
        return r;
    endfunction

    function automatic state_t serve_acc(state_t s, cfg_t c, logic acc, logic m5v);
        state_t r;
        logic   held;
        r    = s;
        held = 1'b0;
        if (!has(r.flags, F_WAKE_ACC)) begin
            r.phase = PH_IDLE;
        end else begin
            if (acc) begin
                if (!has(r.flags, F_WORK)) begin
                    if (m5v) begin
                        r.flags = r.flags | F_WORK | F_HOLD;
                        r.tick  = c.short_delay_ticks;
                        r.phase = PH_ACC_HOLD;
                        held    = 1'b1;
                    end
                end else if (!m5v) begin
                    r.flags = F_HOLD;
                    r.tick  = c.short_delay_ticks;
                end
            end else begin
                r.flags = r.flags & ~F_WAKE_ACC;
                r.tick  = c.short_delay_ticks;
                if (has(r.flags, F_WORK)) begin
                    r.flags = r.flags | F_ENABLE | F_SHUTDOWN;
                end else if (has(r.flags, F_ENABLE)) begin
                    r.flags = r.flags | F_SHUTDOWN;
                end else begin
                    r.flags = r.flags | F_HOLD;
                end
            end
            if (!held && !has(r.flags, F_WAKE_ACC)) begin
                r.phase = PH_IDLE;
            end
        end
        return r;
    endfunction

    function automatic state_t serve_m5v(state_t s, cfg_t c, logic acc, logic m5v);
        state_t r;
        r = s;
        if (!has(r.flags, F_WAKE_M5V)) begin
            r.phase = PH_IDLE;
        end else begin
            if (acc) begin
                r.flags = r.flags & ~F_TIMEOUT;
            end
            if (!m5v) begin
                r.flags = (r.flags & F_ENABLE) | F_HOLD;
                r.tick  = c.short_delay_ticks;
            end
            if (!has(r.flags, F_WAKE_M5V)) begin
                r.phase = PH_IDLE;
            end
        end
        return r;
    endfunction

    function automatic state_t wake_up(state_t s, cfg_t c, logic acc, logic m5v);
        state_t r;
        r = s;
        if (acc) begin
            r.ten = 1'b1;
            if (has(r.flags, F_ENABLE)) begin
                r.tick  = c.one_second_ticks;
                r.flags = r.flags | F_WAKE;
                r.phase = PH_WAKEKEY;
            end else begin
                r.flags = r.flags | F_WAKE_ACC;
                r.phase = PH_ACC;
            end
        end else if (m5v) begin
            r.ten   = 1'b1;
            r.tick  = c.one_second_ticks;
            r.secs  = c.timeout_seconds;
            r.flags = r.flags | F_TIMEOUT | F_WAKE_M5V;
            r.phase = PH_M5V;
        end
        return r;
    endfunction

    // One item: a wake from sleep, or a tick while ticking is on followed by one pass of the main loop.
    function automatic state_t step(state_t s, cfg_t c, logic func, logic acc, logic m5v);
        state_t r;
        r = s;
        if (func) begin
            if (s.phase == PH_SLEEP) begin
                r = wake_up(s, c, acc, m5v);
            end
        end else if (s.phase != PH_SLEEP) begin
            if (r.ten) begin
                r = timer_rules(r, c);
            end
            case (r.phase)
                PH_WAKEKEY: begin
                    if (!has(r.flags, F_WAKE | F_HOLD)) begin
                        r.flags = r.flags | F_WAKE_ACC;
                        r.phase = PH_ACC;
                    end
                end
                PH_ACC: begin
                    r = serve_acc(r, c, acc, m5v);
                end
                PH_ACC_HOLD: begin
                    if (!has(r.flags, F_HOLD)) begin
                        r.phase = PH_ACC;
                    end
                end
                PH_M5V: begin
                    r = serve_m5v(r, c, acc, m5v);
                end
                default: begin
                    if (!has(r.flags, F_HOLD | F_SHUTDOWN) && !m5v) begin
                        r.key   = 1'b0;
                        r.ten   = 1'b0;
                        r.flags = r.flags & F_ENABLE;
                        r.phase = PH_SLEEP;
                    end else begin
                        r.phase = PH_IDLE;
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pkao_ifs.sv
// Valid/ready channel interfaces for the event items and the status items.
`default_nettype none

interface pkao_in_if;
    logic valid;
    logic ready;
    logic func;
    logic acc_on;
    logic m5v_on;

    modport source (output valid, func, acc_on, m5v_on, input ready);
    modport sink (input valid, func, acc_on, m5v_on, output ready);
endinterface

interface pkao_out_if;
    logic valid;
    logic ready;
    logic key_pressed;
    logic sleeping;
    logic ticking;

    modport source (output valid, key_pressed, sleeping, ticking, input ready);
    modport sink (input valid, key_pressed, sleeping, ticking, output ready);
endinterface

`default_nettype wire

FILE: sv/power_key_auto_on_off_sequencer.sv
// Top level of the power key sequencer: input register, step logic and result register.
//
//   Channel  Role    Fields
//   evt      sink    func, acc_on, m5v_on
//   status   source  key_pressed, sleeping, ticking
//   apb      slave   four configuration registers at byte addresses 0, 4, 8, 12
//
// One item is accepted per clock while the status channel is not stalled.
// The state update for an item is combinational flag and counter logic.
// Reset sets the hold flag alone with ticking on, and the configuration to its defaults.
// A stalled status channel holds its result and the next item waits in the input register.
`default_nettype none

module power_key_auto_on_off_sequencer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pkao_in_if.sink                              evt,
    pkao_out_if.source                           status,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pkao_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pkao_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pkao_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    pkao_pkg::cfg_t   cfg;
    pkao_pkg::state_t st_reg;
    pkao_pkg::state_t st_next;
    pkao_pkg::state_t st_step;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_func_reg;
    logic s1_acc_reg;
    logic s1_m5v_reg;
    logic res_valid_reg;
    logic res_valid_next;
    logic res_key_reg;
    logic res_sleep_reg;
    logic res_tick_reg;
    logic advance;
    logic accept;

    pkao_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance   = s1_valid_reg && (!res_valid_reg || status.ready);
    assign evt.ready = !s1_valid_reg || advance;
    assign accept    = evt.valid && evt.ready;

    assign st_step = pkao_pkg::step(st_reg, cfg, s1_func_reg, s1_acc_reg, s1_m5v_reg);

    always_comb
    begin
        st_next        = advance ? st_step : st_reg;
        s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        res_valid_next = advance ? 1'b1 : (status.ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.flags  <= pkao_pkg::F_HOLD;
            st_reg.tick   <= pkao_pkg::ONE_SECOND_RESET;
            st_reg.secs   <= '0;
            st_reg.phase  <= pkao_pkg::PH_IDLE;
            st_reg.key    <= 1'b0;
            st_reg.ten    <= 1'b1;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= evt.func;
            s1_acc_reg  <= evt.acc_on;
            s1_m5v_reg  <= evt.m5v_on;
        end
        if (advance)
        begin
            res_key_reg   <= st_step.key;
            res_sleep_reg <= (st_step.phase == pkao_pkg::PH_SLEEP);
            res_tick_reg  <= st_step.ten;
        end
    end

    assign status.valid       = res_valid_reg;
    assign status.key_pressed = res_key_reg;
    assign status.sleeping    = res_sleep_reg;
    assign status.ticking     = res_tick_reg;

endmodule

`default_nettype wire

FILE: sv/pkao_regs.sv
// APB configuration registers of the power key sequencer.
`default_nettype none

module pkao_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pkao_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pkao_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pkao_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output pkao_pkg::cfg_t                       cfg
);

    pkao_pkg::cfg_t     cfg_reg;
    pkao_pkg::cfg_t     cfg_next;
    pkao_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = pkao_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                pkao_pkg::REG_SHORT_DELAY: cfg_next.short_delay_ticks = pwdata[7:0];
                pkao_pkg::REG_ONE_SECOND:  cfg_next.one_second_ticks  = pwdata[7:0];
                pkao_pkg::REG_TWO_SECOND:  cfg_next.two_second_ticks  = pwdata[7:0];
                pkao_pkg::REG_TIMEOUT:     cfg_next.timeout_seconds   = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pkao_pkg::REG_SHORT_DELAY: prdata = {24'd0, cfg_reg.short_delay_ticks};
            pkao_pkg::REG_ONE_SECOND:  prdata = {24'd0, cfg_reg.one_second_ticks};
            pkao_pkg::REG_TWO_SECOND:  prdata = {24'd0, cfg_reg.two_second_ticks};
            pkao_pkg::REG_TIMEOUT:     prdata = {16'd0, cfg_reg.timeout_seconds};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_delay_ticks <= pkao_pkg::SHORT_DELAY_RESET;
            cfg_reg.one_second_ticks  <= pkao_pkg::ONE_SECOND_RESET;
            cfg_reg.two_second_ticks  <= pkao_pkg::TWO_SECOND_RESET;
            cfg_reg.timeout_seconds   <= pkao_pkg::TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pkao_chk.sv
// Port-level checker of the power key sequencer and its bind to the top level.
`default_nettype none

`include "power_key_auto_on_off_sequencer_defines.svh"

module pkao_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic evt_valid,
    input wire logic evt_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic res_key,
    input wire logic res_sleep,
    input wire logic res_tick
);

    // A result waiting to be taken stays offered.
    `PKAO_ASSERT_NXT(a_res_held, clk, rst_n, res_valid && !res_ready, res_valid)

    // A fresh result only follows an item accepted into the input register.
    `PKAO_ASSERT_IMP(a_res_cause, clk, rst_n, $rose(res_valid), $past(evt_valid && evt_ready, 2))

    // With the result register empty, the block takes items.
    `PKAO_ASSERT_IMP(a_ready_free, clk, rst_n, !res_valid, evt_ready)

    // While asleep the key is released and ticks are not counted.
    `PKAO_ASSERT_IMP(a_sleep_quiet, clk, rst_n, res_valid && res_sleep, !res_key && !res_tick)

endmodule

bind power_key_auto_on_off_sequencer pkao_chk u_pkao_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (status.valid),
    .res_ready (status.ready),
    .res_key   (status.key_pressed),
    .res_sleep (status.sleeping),
    .res_tick  (status.ticking)
);

`default_nettype wire
